### src/score_histogram_accumulator_defines.svh
// assertion macros shared by the score histogram checker
`ifndef SCORE_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define SCORE_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, off during reset
`define SHA_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/sha_pkg.sv
// shared types and constants of the score histogram accumulator
package sha_pkg;

   localparam int SCORE_W     = 20;
   localparam int BIN_INDEX_W = 10;
   localparam int COUNT_W     = 32;
   localparam int SEEN_W      = 16;
   localparam int FRAC_BITS   = 4;

   typedef logic signed [SCORE_W-1:0]  score_type;
   typedef logic [BIN_INDEX_W-1:0]     bin_index_type;
   typedef logic [COUNT_W-1:0]         count_type;
   typedef logic signed [SEEN_W-1:0]   seen_type;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam seen_type  S16_MAX        = 16'sh7fff;
   localparam seen_type  S16_MIN        = -16'sh8000;
   localparam count_type U32_MAX        = '1;
   localparam seen_type  BIN_BASE_RESET = -16'sd512;

   typedef enum logic [2:0] {
      S_CLEAR = 3'b001,
      S_IDLE  = 3'b010,
      S_RMW   = 3'b100
   } state_type;

endpackage

### src/sha_ifs.sv
// handshake channels of the score histogram accumulator
interface sha_req_if;
   import sha_pkg::*;
   logic          valid;
   logic          ready;
   logic          kind;
   score_type     score_fixed;
   bin_index_type bin_index;
   modport source(output valid, kind, score_fixed, bin_index, input ready);
   modport sink(input valid, kind, score_fixed, bin_index, output ready);
endinterface

interface sha_rsp_if;
   import sha_pkg::*;
   logic      valid;
   logic      ready;
   count_type bin_count;
   count_type total_count;
   seen_type  lowest_score;
   seen_type  highest_score;
   logic      is_empty;
   logic      out_of_range;
   modport source(output valid, bin_count, total_count, lowest_score, highest_score,
                  is_empty, out_of_range, input ready);
   modport sink(input valid, bin_count, total_count, lowest_score, highest_score,
                is_empty, out_of_range, output ready);
endinterface

interface sha_csr_if;
   import sha_pkg::*;
   logic     valid;
   logic     ready;
   seen_type data;
   modport source(output valid, data, input ready);
   modport sink(input valid, data, output ready);
endinterface

### src/sha_ram.sv
// generic ram, one write port and one registered read port
module sha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end
endmodule

### src/score_histogram_accumulator.sv
// score histogram accumulator: bins floored fixed-point scores, answers bin reads
// Each request's bin is read from the bin memory in the accept cycle; in S_RMW,
// once the response register can take the beat, the bin is modified, written
// back and registered as the response, and only then is a new request taken.
// The response register holds a finished beat while the next request is already
// being read. After reset the bin memory is cleared one entry per cycle through
// all NUM_BINS entries, with req ready low; the csr channel is always ready.
// Scores are floored toward minus infinity; bins and the total saturate at
// 2^32-1, and a score outside the bins returns out_of_range.
module score_histogram_accumulator #(
   parameter int NUM_BINS = 1024
) (
   input  logic       clock,
   input  logic       reset,
   sha_req_if.sink    req_bus,
   sha_rsp_if.source  rsp_bus,
   sha_csr_if.sink    csr_bus
);
   import sha_pkg::*;

   localparam int AW = $clog2(NUM_BINS);
   localparam int IW = (AW > BIN_INDEX_W) ? AW : BIN_INDEX_W;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   seen_type  base_ff, base_in;
   count_type total_ff, total_in;
   seen_type  low_ff, low_in;
   seen_type  high_ff, high_in;

   logic          kind_ff, kind_in;
   logic          hit_ff, hit_in;
   logic [AW-1:0] addr_ff, addr_in;
   seen_type      s16_ff, s16_in;

   logic      rsp_valid_ff, rsp_valid_in;
   count_type bin_count_ff, bin_count_in;
   count_type total_out_ff;
   seen_type  low_out_ff, high_out_ff;
   logic      empty_ff, oor_ff, oor_in;

   logic                   accept;
   logic                   commit;
   logic                   do_add;
   score_type              int_score;
   logic signed [SCORE_W:0] rel;
   logic [IW-1:0]          idx_wide;
   logic                   add_hit;
   logic                   rd_ok;
   count_type              rd_data;
   count_type              new_cnt;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   count_type              wr_data;

   // accept-side address and range check
   assign accept    = req_bus.valid && req_bus.ready;
   assign int_score = req_bus.score_fixed >>> FRAC_BITS;
   assign rel       = (SCORE_W+1)'(int_score) - (SCORE_W+1)'(base_ff);
   assign add_hit   = !rel[SCORE_W] && (int'(rel) < NUM_BINS);
   assign idx_wide  = IW'(req_bus.bin_index);
   assign rd_ok     = int'(idx_wide) < NUM_BINS;

   always_comb begin
      if (req_bus.kind == KIND_ADD) begin
         hit_in  = add_hit;
         addr_in = rel[AW-1:0];
      end else begin
         hit_in  = rd_ok;
         addr_in = idx_wide[AW-1:0];
      end
      kind_in = req_bus.kind;
      if (int'(int_score) > int'(S16_MAX)) begin
         s16_in = S16_MAX;
      end else if (int'(int_score) < int'(S16_MIN)) begin
         s16_in = S16_MIN;
      end else begin
         s16_in = SEEN_W'(int_score);
      end
   end

   sha_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(NUM_BINS)
   ) u_bins (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (accept),
      .rd_addr    (addr_in),
      .rd_data_ff (rd_data)
   );

   // modify and write-back, only when the response register can take the beat
   assign commit  = (state_ff == S_RMW) && (!rsp_valid_ff || rsp_bus.ready);
   assign do_add  = commit && (kind_ff == KIND_ADD) && hit_ff;
   assign new_cnt = (rd_data == U32_MAX) ? rd_data : rd_data + 1'b1;

   always_comb begin
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else begin
         wr_en   = do_add;
         wr_addr = addr_ff;
         wr_data = new_cnt;
      end
   end

   always_comb begin
      total_in = total_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      if (do_add) begin
         total_in = (total_ff == U32_MAX) ? total_ff : total_ff + 1'b1;
         if (s16_ff < low_ff) begin
            low_in = s16_ff;
         end
         if (s16_ff > high_ff) begin
            high_in = s16_ff;
         end
      end
      if (!hit_ff) begin
         bin_count_in = '0;
      end else if (kind_ff == KIND_ADD) begin
         bin_count_in = new_cnt;
      end else begin
         bin_count_in = rd_data;
      end
      oor_in = (kind_ff == KIND_ADD) && !hit_ff;
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(NUM_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_RMW;
            end
         end
         S_RMW: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   assign base_in = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         base_ff      <= BIN_BASE_RESET;
         total_ff     <= '0;
         low_ff       <= S16_MAX;
         high_ff      <= S16_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         base_ff      <= base_in;
         total_ff     <= total_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_in;
         hit_ff  <= hit_in;
         addr_ff <= addr_in;
         s16_ff  <= s16_in;
      end
      if (commit) begin
         bin_count_ff <= bin_count_in;
         total_out_ff <= total_in;
         low_out_ff   <= low_in;
         high_out_ff  <= high_in;
         empty_ff     <= (total_in == '0);
         oor_ff       <= oor_in;
      end
   end

   assign req_bus.ready         = (state_ff == S_IDLE);
   assign csr_bus.ready         = 1'b1;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.bin_count     = bin_count_ff;
   assign rsp_bus.total_count   = total_out_ff;
   assign rsp_bus.lowest_score  = low_out_ff;
   assign rsp_bus.highest_score = high_out_ff;
   assign rsp_bus.is_empty      = empty_ff;
   assign rsp_bus.out_of_range  = oor_ff;
endmodule

### src/sha_checker.sv
// port-level checks of the score histogram accumulator, bound to the top level
`include "score_histogram_accumulator_defines.svh"

module sha_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [31:0]        bin_count,
   input logic [31:0]        total_count,
   input logic signed [15:0] lowest_score,
   input logic signed [15:0] highest_score,
   input logic               is_empty,
   input logic               out_of_range
);
   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
   `SHA_ASSERT_NEXT(a_req_gap, clock, reset, req_valid && req_ready, !req_ready, "req taken in back-to-back cycles")
   `SHA_ASSERT_IMPLY(a_empty, clock, reset, rsp_valid, is_empty == (total_count == 32'd0), "empty flag disagrees with total")
   `SHA_ASSERT_IMPLY(a_drop, clock, reset, rsp_valid && out_of_range, bin_count == 32'd0, "dropped score shows a bin count")
   `SHA_ASSERT_IMPLY(a_order, clock, reset, rsp_valid && !is_empty, lowest_score <= highest_score, "lowest above highest")
endmodule

bind score_histogram_accumulator sha_checker u_sha_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .bin_count     (rsp_bus.bin_count),
   .total_count   (rsp_bus.total_count),
   .lowest_score  (rsp_bus.lowest_score),
   .highest_score (rsp_bus.highest_score),
   .is_empty      (rsp_bus.is_empty),
   .out_of_range  (rsp_bus.out_of_range)
);

### bench/score_histogram_accumulator_tb.sv
// self-checking testbench of the score histogram accumulator
module score_histogram_accumulator_tb;
   import sha_pkg::*;

   localparam int NUM_BINS      = 1024;
   localparam int CLK_PERIOD    = 20;
   localparam int RESET_CYCLES  = 8;
   localparam int SEGMENTS      = 5;
   localparam int SEG_ITEMS     = 226;
   localparam int HOLD_CYCLES   = 200;
   localparam int DRAIN_CYCLES  = 16;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int PRINT_CAP     = 100;

   typedef struct {
      logic          kind;
      score_type     score_fixed;
      bin_index_type bin_index;
   } req_beat_type;

   typedef struct {
      count_type bin_count;
      count_type total_count;
      seen_type  lowest_score;
      seen_type  highest_score;
      logic      is_empty;
      logic      out_of_range;
   } rsp_beat_type;

   typedef struct {
      req_beat_type stim;
      bit           known;
      rsp_beat_type want;
   } plan_row_type;

   localparam rsp_beat_type FROM_MODEL = '{32'd0, 32'd0, 16'sd0, 16'sd0, 1'b0, 1'b0};

   logic clock = 1'b0;
   logic reset;

   sha_req_if req_bus ();
   sha_rsp_if rsp_bus ();
   sha_csr_if csr_bus ();

   score_histogram_accumulator #(
      .NUM_BINS(NUM_BINS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // histogram state as the block should hold it
   count_type tally_bins [NUM_BINS] = '{default: '0};
   count_type binned_total = '0;
   seen_type  low_mark     = S16_MAX;
   seen_type  high_mark    = S16_MIN;
   seen_type  base_reg     = BIN_BASE_RESET;

   rsp_beat_type bin_expect_q [$];
   rsp_beat_type bin_want;
   int unsigned  mismatch_count = 0;
   int unsigned  send_idle_pct  = 0;
   int unsigned  rcv_idle_pct   = 0;
   int unsigned  hold_asked     = 0;
   int unsigned  hold_done      = 0;
   logic         hold_rsp       = 1'b0;

   // reset value of bin_base is -512: bins cover scores -512..511
   plan_row_type directed_plan [19] = '{
      '{'{KIND_READ, 20'sd0, 10'd0}, 1'b1,
        '{32'd0, 32'd0, S16_MAX, S16_MIN, 1'b1, 1'b0}},
      '{'{KIND_READ, 20'sd0, 10'd1023}, 1'b1,
        '{32'd0, 32'd0, S16_MAX, S16_MIN, 1'b1, 1'b0}},
      '{'{KIND_ADD, -20'sd8192, 10'd0}, 1'b1,
        '{32'd1, 32'd1, -16'sd512, -16'sd512, 1'b0, 1'b0}},
      '{'{KIND_ADD, 20'sd8191, 10'd0}, 1'b1,
        '{32'd1, 32'd2, -16'sd512, 16'sd511, 1'b0, 1'b0}},
      '{'{KIND_ADD, 20'sd8192, 10'd0}, 1'b1,
        '{32'd0, 32'd2, -16'sd512, 16'sd511, 1'b0, 1'b1}},
      '{'{KIND_ADD, -20'sd8193, 10'd0}, 1'b1,
        '{32'd0, 32'd2, -16'sd512, 16'sd511, 1'b0, 1'b1}},
      '{'{KIND_ADD, 20'sh7ffff, 10'd0}, 1'b1,
        '{32'd0, 32'd2, -16'sd512, 16'sd511, 1'b0, 1'b1}},
      '{'{KIND_ADD, 20'sh80000, 10'd0}, 1'b1,
        '{32'd0, 32'd2, -16'sd512, 16'sd511, 1'b0, 1'b1}},
      '{'{KIND_ADD, -20'sd1, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_ADD, 20'sd0, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_ADD, 20'sd15, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_ADD, -20'sd16, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_ADD, -20'sd17, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_READ, 20'sd0, 10'd511}, 1'b0, FROM_MODEL},
      '{'{KIND_READ, 20'sd0, 10'd512}, 1'b0, FROM_MODEL},
      '{'{KIND_READ, -20'sd1, 10'd1023}, 1'b0, FROM_MODEL},
      '{'{KIND_ADD, 20'sd1600, 10'd1023}, 1'b0, FROM_MODEL},
      '{'{KIND_READ, 20'sd0, 10'd0}, 1'b0, FROM_MODEL},
      '{'{KIND_READ, 20'sd0, 10'd510}, 1'b0, FROM_MODEL}
   };

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   function automatic rsp_beat_type histogram_predict(input req_beat_type it);
      rsp_beat_type r;
      int           score_int;
      int           slot;
      seen_type     score16;
      r.bin_count    = '0;
      r.out_of_range = 1'b0;
      if (it.kind == KIND_ADD) begin
         // arithmetic shift floors toward minus infinity
         score_int = int'(it.score_fixed) >>> FRAC_BITS;
         slot      = score_int - int'(base_reg);
         if (slot < 0 || slot >= NUM_BINS) begin
            r.out_of_range = 1'b1;
         end else begin
            if (score_int > int'(S16_MAX)) score16 = S16_MAX;
            else if (score_int < int'(S16_MIN)) score16 = S16_MIN;
            else score16 = seen_type'(score_int);
            if (tally_bins[slot] != U32_MAX) tally_bins[slot] = tally_bins[slot] + 1'b1;
            r.bin_count = tally_bins[slot];
            if (binned_total != U32_MAX) binned_total = binned_total + 1'b1;
            if (score16 < low_mark) low_mark = score16;
            if (score16 > high_mark) high_mark = score16;
         end
      end else begin
         r.bin_count = tally_bins[it.bin_index];
      end
      r.total_count   = binned_total;
      r.lowest_score  = low_mark;
      r.highest_score = high_mark;
      r.is_empty      = (binned_total == '0);
      return r;
   endfunction

   function automatic req_beat_type draw_score_req();
      req_beat_type it;
      int           pick;
      int           top_slot;
      int           score_int;
      it.kind        = KIND_ADD;
      it.score_fixed = score_type'($urandom);
      it.bin_index   = bin_index_type'($urandom);
      top_slot = 32767 - int'(base_reg);
      if (top_slot > NUM_BINS - 1) top_slot = NUM_BINS - 1;
      pick = $urandom_range(99);
      if (pick < 55) begin
         score_int = int'(base_reg) + int'($urandom_range(top_slot));
         it.score_fixed = score_type'(score_int * (1 << FRAC_BITS)
                                      + int'($urandom_range((1 << FRAC_BITS) - 1)));
      end else if (pick < 85) begin
         it.kind = KIND_READ;
         if ($urandom_range(1) == 1) it.bin_index = bin_index_type'($urandom_range(top_slot));
      end else if (pick < 93) begin
         // one step outside either end of the bins
         if ($urandom_range(1) == 1) score_int = int'(base_reg) - 1;
         else score_int = int'(base_reg) + NUM_BINS;
         if (score_int >= int'(S16_MIN) && score_int <= int'(S16_MAX))
            it.score_fixed = score_type'(score_int * (1 << FRAC_BITS)
                                         + int'($urandom_range((1 << FRAC_BITS) - 1)));
      end
      return it;
   endfunction

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic offer_req(input req_beat_type it, input bit known,
                            input rsp_beat_type want);
      rsp_beat_type forecast;
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.kind        <= it.kind;
      req_bus.score_fixed <= it.score_fixed;
      req_bus.bin_index   <= it.bin_index;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      forecast = histogram_predict(it);
      if (known) bin_expect_q.push_back(want);
      else bin_expect_q.push_back(forecast);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (bin_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_bin_base(input seen_type value);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) @(posedge clock);
      csr_bus.valid <= 1'b0;
      base_reg = value;
   endtask

   // response side: random backpressure plus an occasional long hold
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !reset && !hold_rsp && ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_done) begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
            hold_done++;
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (bin_expect_q.size() == 0) begin
            flag_mismatch("beat with nothing expected", rsp_bus.bin_count, '0);
         end else begin
            bin_want = bin_expect_q.pop_front();
            if (rsp_bus.bin_count !== bin_want.bin_count)
               flag_mismatch("bin_count", rsp_bus.bin_count, bin_want.bin_count);
            if (rsp_bus.total_count !== bin_want.total_count)
               flag_mismatch("total_count", rsp_bus.total_count, bin_want.total_count);
            if (rsp_bus.lowest_score !== bin_want.lowest_score)
               flag_mismatch("lowest_score", rsp_bus.lowest_score, bin_want.lowest_score);
            if (rsp_bus.highest_score !== bin_want.highest_score)
               flag_mismatch("highest_score", rsp_bus.highest_score, bin_want.highest_score);
            if (rsp_bus.is_empty !== bin_want.is_empty)
               flag_mismatch("is_empty", rsp_bus.is_empty, bin_want.is_empty);
            if (rsp_bus.out_of_range !== bin_want.out_of_range)
               flag_mismatch("out_of_range", rsp_bus.out_of_range, bin_want.out_of_range);
         end
      end
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int       seg;
      seen_type next_base;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.kind        = KIND_ADD;
      req_bus.score_fixed = '0;
      req_bus.bin_index   = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // the block clears its bin store after reset; req ready stays low until done
      foreach (directed_plan[i])
         offer_req(directed_plan[i].stim, directed_plan[i].known, directed_plan[i].want);

      for (seg = 0; seg < SEGMENTS; seg++) begin
         wait_drained();
         unique case (seg)
            0: next_base = S16_MIN;
            1: next_base = S16_MAX;
            3: next_base = BIN_BASE_RESET;
            default: next_base = seen_type'(int'($urandom_range(4000)) - 2000);
         endcase
         write_bin_base(next_base);
         send_idle_pct = (seg < 2) ? 23 : (seg < 4) ? 53 : 0;
         rcv_idle_pct <= (seg < 2) ? 53 : (seg < 4) ? 23 : 0;
         for (int n = 0; n < SEG_ITEMS; n++) begin
            // stall the response side long enough to back up the request side
            if ((seg == 2 || seg == 4) && n == 30) hold_asked <= hold_asked + 1;
            offer_req(draw_score_req(), 1'b0, FROM_MODEL);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && bin_expect_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
